// File: hw/rtl/vector_dot_distance_norm_unit_assert.svh
// assertion macros shared by the vector dot / distance / norm unit
// no dependencies; include by bare file name
`ifndef VECTOR_DOT_DISTANCE_NORM_UNIT_ASSERT_SVH
`define VECTOR_DOT_DISTANCE_NORM_UNIT_ASSERT_SVH

// expression must never hold at a clock edge outside reset
`define VDN_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// same-cycle implication
`define VDN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VDN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/vdn_pkg.sv
// shared types and constants of the vector dot / distance / norm unit
// no dependencies
package vdn_pkg;

	localparam int DEF_MAX_LEN    = 256;
	localparam int DEF_ELEM_WIDTH = 16;
	localparam int ACC_W          = 41;
	localparam int TERM_W         = 43;
	localparam int Q_DEPTH        = 2;

	localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [TERM_W-1:0]       TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_DOT  = 2'd0,
		OP_DIST = 2'd1,
		OP_MAG  = 2'd2
	} op_t;

	// one finished vector, handed from the accumulator to the result side
	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic                    sat;
		op_t                     op;
	} job_t;

endpackage

// File: hw/rtl/vector_dot_distance_norm_unit.sv
// vector dot product / euclidean distance / magnitude unit, top level
// depends on vdn_pkg, vdn_front, vdn_fifo, vdn_back and the assertion header
//
//  channel   handshake        payload
//  input     push / full      a_elem, b_elem, last, opcode
//  result    empty / pop      value, saturated, op_done
//
// one element pair per cycle enters the accumulator while full is low, behind the operand and product registers
// a finished vector waits in a two-entry queue; the square root unit takes one result bit
// per cycle, so a distance or magnitude result passes ST_ROOT, a dot result goes straight to ST_WAIT
// full rises only while a last element sits at the accumulator and the queue is full
// arst_n clears all control state and the accumulator; nothing waits after reset
`include "vector_dot_distance_norm_unit_assert.svh"

module vector_dot_distance_norm_unit #(
	parameter int MAX_LEN    = vdn_pkg::DEF_MAX_LEN,
	parameter int ELEM_WIDTH = vdn_pkg::DEF_ELEM_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [ELEM_WIDTH-1:0]     a_elem,
	input  logic signed [ELEM_WIDTH-1:0]     b_elem,
	input  logic                             last,
	input  logic [1:0]                       opcode,
	input  logic                             push,
	output logic                             full,
	output logic signed [vdn_pkg::ACC_W-1:0] value,
	output logic                             saturated,
	output logic [1:0]                       op_done,
	output logic                             empty,
	input  logic                             pop
);
	import vdn_pkg::*;

	logic q_push, q_full, q_pop, q_empty;
	job_t q_job, q_head;

	vdn_front #(
		.MAX_LEN   (MAX_LEN),
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.a_elem(a_elem),
		.b_elem(b_elem),
		.last  (last),
		.opcode(opcode),
		.push  (push),
		.full  (full),
		.q_full(q_full),
		.q_push(q_push),
		.q_job (q_job)
	);

	vdn_fifo #(
		.DEPTH(Q_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_data(q_job),
		.full   (q_full),
		.rd     (q_pop),
		.rd_data(q_head),
		.empty  (q_empty)
	);

	vdn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.value    (value),
		.saturated(saturated),
		.op_done  (op_done),
		.empty    (empty),
		.pop      (pop)
	);

	`VDN_ASSERT_NEVER(a_no_push_full, clk, arst_n, q_push && q_full, "queue transfer while full")
	`VDN_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, q_pop && q_empty, "queue read while empty")
	`VDN_ASSERT_NEXT(a_push_fills, clk, arst_n, q_push && !q_pop, !q_empty, "queue lost a vector")
	`VDN_ASSERT_IMPL(a_full_cause, clk, arst_n, full, q_full, "input stalled without full queue")

endmodule

// File: hw/rtl/vdn_front.sv
// element intake: operand selection, multiply stage and saturating accumulator
// depends on vdn_pkg
module vdn_front #(
	parameter int MAX_LEN    = vdn_pkg::DEF_MAX_LEN,
	parameter int ELEM_WIDTH = vdn_pkg::DEF_ELEM_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [ELEM_WIDTH-1:0] a_elem,
	input  logic signed [ELEM_WIDTH-1:0] b_elem,
	input  logic                         last,
	input  logic [1:0]                   opcode,
	input  logic                         push,
	output logic                         full,
	input  logic                         q_full,
	output logic                         q_push,
	output vdn_pkg::job_t                q_job
);
	import vdn_pkg::*;

	localparam int OW    = ELEM_WIDTH + 1;
	localparam int PW    = 2 * OW;
	localparam int EXT_W = (PW > TERM_W) ? PW : TERM_W;
	localparam int SUM_W = TERM_W + 2;
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	logic [CNT_W-1:0] cnt_q;
	op_t              held_op_q;
	logic signed [ACC_W-1:0] acc_q;
	logic             sat_q;

	logic          v_s1, neg_s1, skip_s1, last_s1;
	op_t           op_s1;
	logic [OW-1:0] x_s1, y_s1;

	logic          v_s2, neg_s2, skip_s2, last_s2;
	op_t           op_s2;
	logic [PW-1:0] prod_s2;

	logic adv, accept, first, skip, neg;
	op_t  cur_op;
	logic signed [OW-1:0] a_x, b_x, diff;
	logic [OW-1:0] x_c, y_c;

	logic [EXT_W-1:0]        prod_ext;
	logic [TERM_W-1:0]       term;
	logic signed [SUM_W-1:0] acc_x, term_x, sum;
	logic signed [ACC_W-1:0] acc_nx;
	logic                    sat_nx;

	function automatic logic [OW-1:0] abs_val(input logic signed [OW-1:0] x);
		abs_val = x[OW-1] ? OW'(-x) : OW'(x);
	endfunction

	// the whole front stalls while a finished vector cannot enter the queue
	assign adv    = !(v_s2 && last_s2 && q_full);
	assign full   = !adv;
	assign accept = push && adv;
	assign first  = (cnt_q == '0);
	assign skip   = (cnt_q >= CNT_W'(MAX_LEN));

	always_comb begin
		if (first) begin
			unique case (opcode)
				OP_DOT:  cur_op = OP_DOT;
				OP_DIST: cur_op = OP_DIST;
				default: cur_op = OP_MAG;
			endcase
		end else begin
			cur_op = held_op_q;
		end
	end

	always_comb begin
		a_x  = OW'(a_elem);
		b_x  = OW'(b_elem);
		diff = b_x - a_x;
		neg  = 1'b0;
		unique case (cur_op)
			OP_DOT: begin
				x_c = abs_val(a_x);
				y_c = abs_val(b_x);
				neg = a_elem[ELEM_WIDTH-1] ^ b_elem[ELEM_WIDTH-1];
			end
			OP_DIST: begin
				x_c = abs_val(diff);
				y_c = abs_val(diff);
			end
			default: begin
				x_c = abs_val(a_x);
				y_c = abs_val(a_x);
			end
		endcase
	end

	// cap the product, add or subtract, clamp; past MAX_LEN only flag sat
	always_comb begin
		prod_ext = EXT_W'(prod_s2);
		term     = (prod_ext > EXT_W'(TERM_CAP)) ? TERM_CAP : prod_ext[TERM_W-1:0];
		acc_x    = SUM_W'(acc_q);
		term_x   = $signed(SUM_W'(term));
		sum      = neg_s2 ? (acc_x - term_x) : (acc_x + term_x);
		acc_nx   = acc_q;
		sat_nx   = sat_q;
		if (skip_s2) begin
			sat_nx = 1'b1;
		end else if (sum > SUM_W'(ACC_MAX)) begin
			acc_nx = ACC_MAX;
			sat_nx = 1'b1;
		end else if (sum < SUM_W'(ACC_MIN)) begin
			acc_nx = ACC_MIN;
			sat_nx = 1'b1;
		end else begin
			acc_nx = sum[ACC_W-1:0];
		end
	end

	assign q_push    = adv && v_s2 && last_s2;
	assign q_job.acc = acc_nx;
	assign q_job.sat = sat_nx;
	assign q_job.op  = op_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			held_op_q <= OP_DOT;
			acc_q     <= '0;
			sat_q     <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				held_op_q <= cur_op;
				if (last) begin
					cnt_q <= '0;
				end else if (!skip) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (v_s2) begin
				if (last_s2) begin
					acc_q <= '0;
					sat_q <= 1'b0;
				end else begin
					acc_q <= acc_nx;
					sat_q <= sat_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= x_c;
			y_s1    <= y_c;
			neg_s1  <= neg;
			skip_s1 <= skip;
			last_s1 <= last;
			op_s1   <= cur_op;
			prod_s2 <= PW'(x_s1) * PW'(y_s1);
			neg_s2  <= neg_s1;
			skip_s2 <= skip_s1;
			last_s2 <= last_s1;
			op_s2   <= op_s1;
		end
	end

endmodule

// File: hw/rtl/vdn_fifo.sv
// short queue of finished vectors between accumulator and result side
// depends on vdn_pkg
module vdn_fifo #(
	parameter int DEPTH = vdn_pkg::Q_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  vdn_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd,
	output vdn_pkg::job_t rd_data,
	output logic          empty
);
	import vdn_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hw/rtl/vdn_back.sv
// result side: iterative floor square root and the output register
// depends on vdn_pkg
module vdn_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  vdn_pkg::job_t                    q_head,
	output logic                             q_pop,
	output logic signed [vdn_pkg::ACC_W-1:0] value,
	output logic                             saturated,
	output logic [1:0]                       op_done,
	output logic                             empty,
	input  logic                             pop
);
	import vdn_pkg::*;

	localparam int SQ_W   = ACC_W - 1;
	localparam int STEPS  = SQ_W / 2;
	localparam int ROOT_W = STEPS;
	localparam int REM_W  = ROOT_W + 3;
	localparam int STEP_W = $clog2(STEPS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROOT = 3'b010,
		ST_WAIT = 3'b100
	} bk_state_t;

	bk_state_t state_q;
	logic      out_valid_q;
	logic [STEP_W-1:0] step_q;
	logic [SQ_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic signed [ACC_W-1:0] res_q;
	logic  sat_q;
	op_t   op_q;
	logic signed [ACC_W-1:0] value_q;
	logic  saturated_q;
	op_t   op_done_q;

	logic [REM_W-1:0]  rem_sh, trial, rem_nx;
	logic [ROOT_W-1:0] root_nx;
	logic              load_out, root_end;

	// one result bit per cycle, two radicand bits shifted in
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
		if (rem_sh >= trial) begin
			rem_nx  = rem_sh - trial;
			root_nx = {root_q[ROOT_W-2:0], 1'b1};
		end else begin
			rem_nx  = rem_sh;
			root_nx = {root_q[ROOT_W-2:0], 1'b0};
		end
	end

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign root_end = (state_q == ST_ROOT) && (step_q == STEP_W'(STEPS - 1));
	assign load_out = (state_q == ST_WAIT) && (!out_valid_q || pop);

	assign value     = value_q;
	assign saturated = saturated_q;
	assign op_done   = op_done_q;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (!q_empty) begin
						state_q <= (q_head.op == OP_DOT) ? ST_WAIT : ST_ROOT;
					end
				end
				ST_ROOT: begin
					step_q <= step_q + 1'b1;
					if (root_end) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sat_q  <= q_head.sat;
			op_q   <= q_head.op;
			res_q  <= q_head.acc;
			rad_q  <= q_head.acc[ACC_W-1] ? '0 : q_head.acc[SQ_W-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == ST_ROOT) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= rem_nx;
			root_q <= root_nx;
			if (root_end) begin
				res_q <= $signed(ACC_W'(root_nx));
			end
		end
		if (load_out) begin
			value_q     <= res_q;
			saturated_q <= sat_q;
			op_done_q   <= op_q;
		end
	end

endmodule
